@@ src/pseu_pkg.sv @@
// Shared types and constants of the particle store Euler update unit.
// No dependencies.
`default_nettype none
package pseu_pkg;
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_LIVE  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // Stored particle: 32x2 pos, 32x2 vel, rot, spin, life, maxlife, drag, grav, fade, alpha.
  localparam int unsigned PART_W = 32*6 + 24*2 + 16 + 32 + 1 + 8;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [31:0]        rot;
    logic signed [31:0] spin;
    logic [23:0]        life;
    logic [23:0]        maxlife;
    logic [15:0]        drag;
    logic signed [31:0] grav;
    logic               fade;
    logic [7:0]         alpha;
  } part_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SPAWN, S_RD, S_WAIT, S_MUL1, S_MUL2, S_MUL3, S_DIV, S_WB,
    S_EMPTY, S_OUT_RD, S_OUT_WAIT, S_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_in;      // capture request payload
    logic spawn_wr;     // write new particle at live count
    logic cap_part;     // capture read data
    logic mul1;         // drag products
    logic mul2;         // drag result, gravity and rotation products
    logic mul3;         // gravity on vy, rotation update
    logic div_start;    // start alpha division, position products, life update
    logic wb;           // write survivor back
    logic rd_out;       // read entry at output index
    logic out_load_live;
    logic out_load_spawn;
    logic out_load_none;
    logic tick_init;
    logic src_inc;
    logic out_inc;
    logic out_init;
    logic finish_tick;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic full;
    logic src_done;
    logic survives;
    logic need_div;
    logic div_done;
    logic out_done;
    logic none_left;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

@@ src/pseu_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module pseu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/pseu_div.sv @@
// Radix-2 restoring divider for the fade alpha: floor(life*255/maxlife).
// Depends on nothing; 8 quotient bits since life <= maxlife.
`default_nettype none
module pseu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [23:0] life,
  input  wire logic [23:0] maxlife,
  output logic             done,
  output logic [7:0]       quot
);
  logic [32:0] rem;
  logic [23:0] dvs;
  logic [3:0]  cnt;
  logic        busy;
  logic [32:0] num;
  logic [33:0] trial;
  assign num = {1'b0, life, 8'd0} - {9'd0, life};
  // Remainder shifted one place, minus divisor aligned to bit 8 onward.
  assign trial = {rem, 1'b0} - {2'b0, dvs, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd8;
        rem  <= num;
        dvs  <= maxlife;
        quot <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem  <= trial[32:0];
          quot <= {quot[6:0], 1'b1};
        end else begin
          rem  <= {rem[31:0], 1'b0};
          quot <= {quot[6:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ src/pseu_datapath.sv @@
// Datapath: particle RAM, index counters, Euler arithmetic, output register.
// Depends on pseu_pkg, pseu_ram and pseu_div.
`default_nettype none
module pseu_datapath
  import pseu_pkg::*;
#(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic               opcode,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic [23:0]        time_value,
  input  wire logic signed [31:0] start_rotation,
  input  wire logic signed [31:0] spin_rate,
  input  wire logic [15:0]        drag_factor,
  input  wire logic signed [31:0] gravity_accel,
  input  wire logic               fade_enable,
  input  wire logic [7:0]         start_alpha,
  input  wire logic               out_ready,
  output logic [1:0]              kind,
  output logic                    accepted,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_rotation,
  output logic [7:0]              out_alpha,
  output logic [23:0]             life_left,
  output logic                    last,
  output logic                    out_valid
);
  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_PARTICLES);

  logic [CW-1:0] live_count, src, dst;
  logic [CW-1:0] oidx;
  logic          opc;
  logic [23:0]   dt;
  part_t         in_part, p;
  logic [PART_W-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  part_t         wdata;
  part_t         wb_part;
  logic signed [48:0] pvx, pvy;
  logic signed [56:0] pg, ps, px, py;
  logic          div_done;
  logic [7:0]    quot;
  logic [23:0]   life_next;
  logic signed [31:0] nx, ny;

  function automatic logic signed [31:0] sat(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign life_next = p.life - dt;

  // Final position from the registered products; valid in the writeback state.
  assign nx = sat(50'($signed(p.x)) + 50'(px >>> 16));
  assign ny = sat(50'($signed(p.y)) + 50'(py >>> 16));

  // Survivor written back with its new position and, when fading, the divider's alpha.
  always_comb begin
    wb_part = p;
    wb_part.x = nx;
    wb_part.y = ny;
    if (p.fade) wb_part.alpha = quot;
  end

  assign we    = cmd.spawn_wr || cmd.wb;
  assign waddr = cmd.spawn_wr ? live_count[AW-1:0] : dst[AW-1:0];
  assign wdata = cmd.spawn_wr ? in_part : wb_part;
  assign raddr = cmd.rd_out ? oidx[AW-1:0] : src[AW-1:0];

  pseu_ram #(.WIDTH(PART_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  pseu_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .life(life_next), .maxlife(p.maxlife),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opc <= opcode;
      dt  <= time_value;
      in_part <= '{x: pos_x, y: pos_y, vx: vel_x, vy: vel_y, rot: start_rotation,
                   spin: spin_rate, life: time_value, maxlife: time_value,
                   drag: drag_factor, grav: gravity_accel, fade: fade_enable,
                   alpha: start_alpha};
    end
    if (cmd.cap_part) p <= rdata;
    if (cmd.mul1) begin
      pvx <= p.vx * $signed({1'b0, p.drag});
      pvy <= p.vy * $signed({1'b0, p.drag});
    end
    if (cmd.mul2) begin
      p.vx <= sat(50'(pvx >>> 15));
      p.vy <= sat(50'(pvy >>> 15));
      pg   <= p.grav * $signed({1'b0, dt});
      ps   <= p.spin * $signed({1'b0, dt});
    end
    if (cmd.mul3) begin
      // Gravity lands on vy before the position products are formed.
      p.vy  <= sat(50'($signed(p.vy)) + 50'(pg >>> 16));
      p.rot <= p.rot + 32'(ps >>> 16);
    end
    if (cmd.div_start) begin
      px <= p.vx * $signed({1'b0, dt});
      py <= p.vy * $signed({1'b0, dt});
      p.life <= life_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      src <= '0;
      dst <= '0;
      oidx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.spawn_wr) live_count <= live_count + 1'b1;
      if (cmd.tick_init) begin
        src <= '0;
        dst <= '0;
      end
      if (cmd.src_inc) src <= src + 1'b1;
      if (cmd.wb) dst <= dst + 1'b1;
      if (cmd.finish_tick) live_count <= dst;
      if (cmd.out_init) oidx <= '0;
      if (cmd.out_inc) oidx <= oidx + 1'b1;
      if (cmd.out_load_live || cmd.out_load_spawn || cmd.out_load_none) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load_spawn) begin
      kind <= KIND_SPAWN; accepted <= (live_count < CAP);
      out_x <= '0; out_y <= '0; out_rotation <= '0; out_alpha <= '0;
      life_left <= '0; last <= 1'b1;
    end else if (cmd.out_load_none) begin
      kind <= KIND_NONE; accepted <= 1'b0;
      out_x <= '0; out_y <= '0; out_rotation <= '0; out_alpha <= '0;
      life_left <= '0; last <= 1'b1;
    end else if (cmd.out_load_live) begin
      kind <= KIND_LIVE; accepted <= 1'b0;
      out_x <= p.x; out_y <= p.y; out_rotation <= p.rot; out_alpha <= p.alpha;
      life_left <= p.life; last <= (oidx + 1'b1 == live_count);
    end
  end

  assign stat.opcode    = opc;
  assign stat.full      = (live_count >= CAP);
  assign stat.src_done  = (src == live_count);
  assign stat.survives  = (p.life > dt);
  assign stat.need_div  = p.fade;
  assign stat.div_done  = div_done;
  assign stat.out_done  = (oidx == live_count);
  assign stat.none_left = (live_count == '0);
  assign stat.out_busy  = out_valid && !out_ready;
endmodule
`default_nettype wire

@@ src/pseu_ctrl.sv @@
// Controller state machine sequencing spawn, tick integration and emission.
// Depends on pseu_pkg.
`default_nettype none
module pseu_ctrl
  import pseu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          cmd.load_in = 1'b1;
          state_next = S_SPAWN;
        end
      end
      S_SPAWN: begin
        if (stat.opcode == OP_SPAWN) begin
          cmd.out_load_spawn = 1'b1;
          cmd.spawn_wr = !stat.full;
          state_next = S_IDLE;
        end else begin
          cmd.tick_init = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.src_done) begin
          cmd.finish_tick = 1'b1;
          state_next = S_EMPTY;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.cap_part = 1'b1;
        cmd.src_inc = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin cmd.mul1 = 1'b1; state_next = S_MUL2; end
      S_MUL2: begin cmd.mul2 = 1'b1; state_next = S_MUL3; end
      S_MUL3: begin
        cmd.mul3 = 1'b1;
        state_next = stat.survives ? S_DIV : S_RD;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        if (stat.div_done || !stat.need_div) begin
          cmd.wb = 1'b1;
          state_next = S_RD;
        end
      end
      S_EMPTY: begin
        cmd.out_init = 1'b1;
        if (stat.none_left) begin
          cmd.out_load_none = 1'b1;
          state_next = S_IDLE;
        end else state_next = S_OUT_RD;
      end
      S_OUT_RD: begin
        if (!stat.out_busy) begin
          cmd.rd_out = 1'b1;
          state_next = S_OUT_WAIT;
        end
      end
      S_OUT_WAIT: begin
        cmd.cap_part = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load_live = 1'b1;
        cmd.out_inc = 1'b1;
        state_next = S_OUT_RD;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_OUT_RD && stat.out_done) begin
      cmd.rd_out = 1'b0;
      state_next = S_IDLE;
    end
  end

  a_wb_only_live: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |-> state == S_WB) else $error("writeback outside WB");
  a_no_double_wr: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wb && cmd.spawn_wr)) else $error("two RAM writes");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == S_SPAWN) else $error("bad accept");
endmodule
`default_nettype wire

@@ src/particle_store_euler_update_unit.sv @@
// Top level of the particle store Euler update unit.
// Depends on pseu_pkg, pseu_ctrl and pseu_datapath.
`default_nettype none
// A spawn request stores one particle (or is refused when full) and its single
// answer is loaded into the output register in the cycle after the request is
// accepted; a new request is taken only once the unit is back in idle. A tick
// request walks the stored particles one at a time through a simple dual-port
// RAM: a particle that dies passes through read, capture and three multiply
// steps, a survivor also through the position step that starts the divider
// and the writeback, and a fading survivor's writeback further waits for the
// eight-step alpha divider. Every survivor is then read back and emitted
// through read, capture and output load steps. Results wait in an output
// register, and emission stalls while a result is not taken.
module particle_store_euler_update_unit
  import pseu_pkg::*;
#(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic [23:0]        time_value,
  input  wire logic signed [31:0] start_rotation,
  input  wire logic signed [31:0] spin_rate,
  input  wire logic [15:0]        drag_factor,
  input  wire logic signed [31:0] gravity_accel,
  input  wire logic               fade_enable,
  input  wire logic [7:0]         start_alpha,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              kind,
  output logic                    accepted,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_rotation,
  output logic [7:0]              out_alpha,
  output logic [23:0]             life_left,
  output logic                    last
);
  cmd_t  cmd;
  stat_t stat;

  pseu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  pseu_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .time_value(time_value), .start_rotation(start_rotation), .spin_rate(spin_rate),
    .drag_factor(drag_factor), .gravity_accel(gravity_accel),
    .fade_enable(fade_enable), .start_alpha(start_alpha), .out_ready(out_ready),
    .kind(kind), .accepted(accepted), .out_x(out_x), .out_y(out_y),
    .out_rotation(out_rotation), .out_alpha(out_alpha), .life_left(life_left),
    .last(last), .out_valid(out_valid)
  );

  // A result that is not taken stays up with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(out_x) &&
                                   $stable(life_left) && $stable(last)))
    else $error("result changed while waiting");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("accept while result stalled");
endmodule
`default_nettype wire
